// ===== rtl/aikg_pkg.sv =====
// Shared types and codes of the auto-increment key generator.
package aikg_pkg;

	typedef enum logic [1:0] {
		OP_GENERATE = 2'd0,
		OP_VALIDATE = 2'd1,
		OP_TRACK    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_ALLOWED = 2'd1,
		ST_EXHAUSTED   = 2'd2
	} status_t;

	localparam logic [1:0] CFG_ALLOW_USER_KEYS = 2'd0;
	localparam logic [1:0] CFG_KEY_OFFSET      = 2'd1;
	localparam logic [1:0] CFG_KEY_INCREMENT   = 2'd2;

	localparam int INC_WIDTH = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIMPLE,
		S_PREP,
		S_DIV,
		S_ADJ,
		S_CLAMP,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic adj;
		logic clamp;
		logic finish_gen;
		logic finish_simple;
	} dp_cmd_t;

	typedef struct packed {
		logic is_gen;
		logic below_off;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/aikg_ctrl.sv =====
// Sequencer of the key generator: steps the datapath through one beat at a time.
module aikg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aikg_pkg::dp_stat_t stat,
	output aikg_pkg::dp_cmd_t  cmd
);

	aikg_pkg::state_t state_q;
	aikg_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aikg_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aikg_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.is_gen ? aikg_pkg::S_PREP : aikg_pkg::S_SIMPLE;
				end
			end
			aikg_pkg::S_SIMPLE: begin
				if (stat.out_free) begin
					state_nxt = aikg_pkg::S_IDLE;
				end
			end
			aikg_pkg::S_PREP: begin
				// Below the offset the offset itself is the candidate.
				state_nxt = stat.below_off ? aikg_pkg::S_CHECK : aikg_pkg::S_DIV;
			end
			aikg_pkg::S_DIV: begin
				if (stat.div_last) begin
					state_nxt = aikg_pkg::S_ADJ;
				end
			end
			aikg_pkg::S_ADJ: begin
				state_nxt = aikg_pkg::S_CLAMP;
			end
			aikg_pkg::S_CLAMP: begin
				state_nxt = aikg_pkg::S_CHECK;
			end
			aikg_pkg::S_CHECK: begin
				if (stat.out_free) begin
					state_nxt = aikg_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = aikg_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			aikg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			aikg_pkg::S_SIMPLE: begin
				cmd.finish_simple = stat.out_free;
			end
			aikg_pkg::S_PREP: begin
				cmd.prep = 1'b1;
			end
			aikg_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			aikg_pkg::S_ADJ: begin
				cmd.adj = 1'b1;
			end
			aikg_pkg::S_CLAMP: begin
				cmd.clamp = 1'b1;
			end
			aikg_pkg::S_CHECK: begin
				cmd.finish_gen = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/aikg_dp.sv =====
// Datapath of the key generator: last value, serial remainder and result register.
module aikg_dp #(
	parameter int KEY_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aikg_pkg::dp_cmd_t                   cmd,
	output aikg_pkg::dp_stat_t                  stat,
	input  logic                                allow_user,
	input  logic [KEY_WIDTH-1:0]                offset,
	input  logic [aikg_pkg::INC_WIDTH-1:0]      increment,
	input  logic [1:0]                          op,
	input  logic [63:0]                         key_value,
	input  logic                                is_restore,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [63:0]                         key_out,
	output logic [1:0]                          status
);

	localparam int CW = $clog2(KEY_WIDTH);
	localparam int IW = aikg_pkg::INC_WIDTH;

	aikg_pkg::op_t           op_q;
	logic [KEY_WIDTH-1:0]    key_q;
	logic                    restore_q;
	logic [KEY_WIDTH-1:0]    last_q;
	logic [KEY_WIDTH-1:0]    dvd_q;
	logic [IW-1:0]           rem_q;
	logic [CW-1:0]           cnt_q;
	logic [KEY_WIDTH-1:0]    kv_q;
	logic                    out_valid_q;
	logic [63:0]             key_out_q;
	aikg_pkg::status_t       status_q;

	logic                    out_free;
	logic [IW:0]             trial;
	logic [IW-1:0]           rem_nxt;
	logic [IW-1:0]           step;
	logic                    kv_bad;
	logic                    user_refused;
	logic                    raise;
	logic [KEY_WIDTH-1:0]    last_simple;
	aikg_pkg::status_t       status_simple;

	assign out_free = !out_valid_q || out_ready;

	assign stat.is_gen    = (op == aikg_pkg::OP_GENERATE);
	assign stat.below_off = (last_q < offset);
	assign stat.div_last  = (cnt_q == '0);
	assign stat.out_free  = out_free;

	// One restoring step of the remainder; the partial remainder stays below the increment.
	assign trial   = {rem_q, dvd_q[KEY_WIDTH-1]};
	assign rem_nxt = (trial >= {1'b0, increment}) ? IW'(trial - {1'b0, increment})
	                                              : trial[IW-1:0];

	assign step   = increment - rem_q;
	assign kv_bad = (kv_q == {KEY_WIDTH{1'b1}}) || (kv_q < last_q);

	assign user_refused = (op_q == aikg_pkg::OP_VALIDATE) && !allow_user && !restore_q;
	assign raise = ((op_q == aikg_pkg::OP_VALIDATE) || (op_q == aikg_pkg::OP_TRACK))
	               && !user_refused && (key_q > last_q);

	always_comb begin
		last_simple   = raise ? key_q : last_q;
		status_simple = user_refused ? aikg_pkg::ST_NOT_ALLOWED : aikg_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= aikg_pkg::op_t'(op);
			key_q     <= key_value[KEY_WIDTH-1:0];
			restore_q <= is_restore;
		end
		if (cmd.prep) begin
			kv_q  <= offset;
			dvd_q <= last_q - offset;
			rem_q <= '0;
			cnt_q <= CW'(KEY_WIDTH - 1);
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[KEY_WIDTH-2:0], 1'b0};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.adj) begin
			kv_q <= last_q + KEY_WIDTH'(step);
		end
		if (cmd.clamp) begin
			// A sum that wrapped below the offset restarts at the offset.
			if (kv_q < offset) begin
				kv_q <= offset;
			end
		end
		if (cmd.finish_gen) begin
			key_out_q <= kv_bad ? 64'(last_q) : 64'(kv_q);
			status_q  <= kv_bad ? aikg_pkg::ST_EXHAUSTED : aikg_pkg::ST_OK;
		end
		if (cmd.finish_simple) begin
			key_out_q <= 64'(last_simple);
			status_q  <= status_simple;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish_gen && !kv_bad) begin
				last_q <= kv_q;
			end
			if (cmd.finish_simple) begin
				last_q <= last_simple;
			end
			if (cmd.finish_gen || cmd.finish_simple) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign key_out   = key_out_q;
	assign status    = status_q;

endmodule

// ===== rtl/auto_increment_key_generator.sv =====
// Top level of the auto-increment key generator: configuration registers and wiring.
//
// Hands out numeric keys on the grid key_offset + k * key_increment above the
// largest key seen so far, and tracks user and stored keys. One item is worked
// on at a time. Validate, track and unknown ops pass from accept through S_SIMPLE
// back to idle. Generate steps through S_PREP, S_DIV, S_ADJ, S_CLAMP and
// S_CHECK; S_DIV forms the remainder of (last value - offset) by the increment
// one bit per cycle. While the last value is still below the offset generate
// goes from S_PREP straight to S_CHECK. The result sits in an output register, so a
// stalled consumer holds only the final write. Configuration writes are always
// taken and should be made while no item is in flight. Only the low KEY_WIDTH
// bits of the offset and of key_value are used; an increment of zero acts as one.
module auto_increment_key_generator #(
	parameter int KEY_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] key_value,
	input  logic        is_restore,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] key_out,
	output logic [1:0]  status
);

	logic                              allow_q;
	logic [63:0]                       offset_q;
	logic [aikg_pkg::INC_WIDTH-1:0]    inc_q;
	logic [aikg_pkg::INC_WIDTH-1:0]    inc_eff;
	aikg_pkg::dp_cmd_t                 cmd;
	aikg_pkg::dp_stat_t                stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q  <= 1'b1;
			offset_q <= '0;
			inc_q    <= aikg_pkg::INC_WIDTH'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				aikg_pkg::CFG_ALLOW_USER_KEYS: allow_q  <= cfg_data[0];
				aikg_pkg::CFG_KEY_OFFSET:      offset_q <= cfg_data;
				aikg_pkg::CFG_KEY_INCREMENT:   inc_q    <= cfg_data[aikg_pkg::INC_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign inc_eff = (inc_q == '0) ? aikg_pkg::INC_WIDTH'(1) : inc_q;

	aikg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aikg_dp #(
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.allow_user (allow_q),
		.offset     (offset_q[KEY_WIDTH-1:0]),
		.increment  (inc_eff),
		.op         (op),
		.key_value  (key_value),
		.is_restore (is_restore),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_out    (key_out),
		.status     (status)
	);

endmodule

// ===== verif/aikg_key_checker.sv =====
// Checker for the key generator: predicts each granted key and status and compares the results.
module aikg_key_checker
	import aikg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] key_value,
	input  logic        is_restore,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] key_out,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [63:0] key;
		status_t     st;
	} key_grant_t;

	key_grant_t  granted_q[$];
	logic        allow_keys;
	logic [63:0] key_base;
	logic [15:0] key_step;
	logic [63:0] last_key;

	function automatic void flag(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Works out the result of one item and moves the tracked last key on.
	function automatic key_grant_t grant_key(input logic [1:0] op_i, input logic [63:0] key_i,
			input logic restore_i);
		key_grant_t  g;
		logic [63:0] step;
		logic [63:0] cand;
		step = (key_step == '0) ? 64'd1 : {48'd0, key_step};
		g.st = ST_OK;
		case (op_i)
			OP_GENERATE: begin
				if (last_key < key_base) begin
					cand = key_base;
				end else begin
					// The sum may wrap at 64 bits; a wrapped key below the base falls back to the base.
					cand = last_key + step - ((last_key - key_base) % step);
					if (cand < key_base) begin
						cand = key_base;
					end
				end
				if (cand == '1 || cand < last_key) begin
					g.st = ST_EXHAUSTED;
				end else begin
					last_key = cand;
				end
			end
			OP_VALIDATE: begin
				if (!allow_keys && !restore_i) begin
					g.st = ST_NOT_ALLOWED;
				end else if (key_i > last_key) begin
					last_key = key_i;
				end
			end
			OP_TRACK: begin
				if (key_i > last_key) begin
					last_key = key_i;
				end
			end
			default: begin
			end
		endcase
		g.key = last_key;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_grant_t exp_g;
		if (!arst_n) begin
			allow_keys = 1'b1;
			key_base   = '0;
			key_step   = 16'd1;
			last_key   = '0;
			granted_q.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			// The output beat is checked first, as it can never belong to an item taken at this edge.
			if (out_valid && out_ready) begin
				if (granted_q.size() == 0) begin
					flag($sformatf("unexpected result: key %h status %0d", key_out, status));
				end else begin
					exp_g = granted_q.pop_front();
					if (key_out !== exp_g.key || status !== exp_g.st) begin
						flag($sformatf("mismatch: key exp %h got %h, status exp %0d got %0d",
							exp_g.key, key_out, exp_g.st, status));
					end
				end
			end
			if (in_valid && in_ready) begin
				granted_q.push_back(grant_key(op, key_value, is_restore));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALLOW_USER_KEYS: allow_keys = cfg_data[0];
					CFG_KEY_OFFSET:      key_base = cfg_data;
					CFG_KEY_INCREMENT:   key_step = cfg_data[15:0];
					default: begin
					end
				endcase
			end
			pending = granted_q.size();
		end
	end

endmodule

// ===== verif/auto_increment_key_generator_tb.sv =====
// Testbench top for the key generator: clock, reset, stimulus, flow control and verdict.
module auto_increment_key_generator_tb;
	import aikg_pkg::*;

	localparam logic [1:0] OP_UNKNOWN  = 2'd3;
	localparam int         NPHASE      = 13;
	localparam int         PHASE_ITEMS = 150;
	localparam int         HOLD_CYCLES = 300;
	localparam int         QUIET_LIMIT = 4000;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index  = '0;
	logic [63:0] cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  op         = '0;
	logic [63:0] key_value  = '0;
	logic        is_restore = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [63:0] key_out;
	logic [1:0]  status;

	int errors;
	int pending;
	int burst_left   = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	auto_increment_key_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .key_value(key_value), .is_restore(is_restore),
		.out_valid(out_valid), .out_ready(out_ready), .key_out(key_out), .status(status)
	);

	aikg_key_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .key_value(key_value), .is_restore(is_restore),
		.out_valid(out_valid), .out_ready(out_ready), .key_out(key_out), .status(status),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (out_valid && out_ready) begin
			results_seen++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no beat on any channel for %0d cycles", QUIET_LIMIT);
			$display("[auto_increment_key_generator] ERROR");
			$finish;
		end
	end

	// Result side: ready follows a mode picked anew for each random span, and twice
	// it holds off for a long stretch so that the block backs up onto its input.
	initial begin : result_sink
		int mode;
		int span;
		int hold_at;
		hold_at = 400;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(negedge clk);
				if (results_seen >= hold_at) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_at += 1000;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic issue(input logic [1:0] o, input logic [63:0] k, input logic r);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		op         <= o;
		key_value  <= k;
		is_restore <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering items and waits until every outstanding result has come back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic allow, input logic [63:0] base, input logic [15:0] step);
		write_reg(CFG_ALLOW_USER_KEYS, {63'd0, allow});
		write_reg(CFG_KEY_OFFSET, base);
		write_reg(CFG_KEY_INCREMENT, {48'd0, step});
	endtask

	// The last key only ever rises, so each phase works in a higher band of the key space.
	task automatic run_phase(input int p);
		logic [63:0] base;
		logic [63:0] k;
		logic [15:0] step;
		logic        allow;
		logic        rs;
		int          r;
		base  = (p == NPHASE - 1) ? 64'hFFFF_FFFF_FF00_0000 : 64'(p) * 64'h1400_0000_0000_0000;
		allow = (p % 3 != 1);
		case (p % 5)
			0: step = 16'd1;
			1: step = 16'hFFFF;
			2: step = 16'd0;
			3: step = 16'($urandom_range(2, 16));
			default: step = 16'($urandom_range(17, 65535));
		endcase
		set_regs(allow, base + 64'($urandom_range(0, 65535)), step);
		repeat (PHASE_ITEMS) begin
			r  = $urandom_range(0, 99);
			k  = base + 64'($urandom_range(0, 24'hFF_FFFF));
			rs = $urandom_range(0, 1);
			if (r < 45) begin
				issue(OP_GENERATE, {$urandom, $urandom}, rs);
			end else if (r < 70) begin
				issue(OP_TRACK, k, rs);
			end else if (r < 92) begin
				// A refused key leaves the state alone, so it may take any value.
				issue(OP_VALIDATE, (!allow && !rs) ? {$urandom, $urandom} : k, rs);
			end else if (r < 97) begin
				issue(r[0] ? OP_TRACK : OP_VALIDATE, 64'($urandom), rs);
			end else begin
				issue(OP_UNKNOWN, {$urandom, $urandom}, rs);
			end
		end
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: offset zero, step one, user keys allowed.
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_GENERATE, '1, 1'b1);
		issue(OP_UNKNOWN, '1, 1'b1);
		issue(OP_TRACK, 64'd5, 1'b0);
		issue(OP_TRACK, 64'd3, 1'b1);
		issue(OP_VALIDATE, 64'd10, 1'b0);

		// User keys off and a zero step, which must behave as a step of one.
		set_regs(1'b0, 64'd100, 16'd0);
		issue(OP_VALIDATE, '1, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_VALIDATE, 64'd1000, 1'b1);
		issue(OP_GENERATE, '0, 1'b0);

		set_regs(1'b1, 64'd1003, 16'hFFFF);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_TRACK, 64'd70000, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);

		// With an all-ones offset generate can only ever report exhaustion.
		set_regs(1'b1, '1, 16'd7);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_VALIDATE, '0, 1'b1);

		for (int p = 0; p < NPHASE; p++) begin
			run_phase(p);
		end

		// Top of the key space: a wrap that lands back on the last key hands it out again.
		set_regs(1'b1, 64'hFFFF_FFFF_FFFF_FFFD, 16'd5);
		issue(OP_TRACK, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		set_regs(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0);
		issue(OP_TRACK, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		set_regs(1'b0, '0, 16'hFFFF);
		issue(OP_TRACK, '1, 1'b0);
		issue(OP_GENERATE, '0, 1'b0);
		issue(OP_VALIDATE, '0, 1'b0);
		issue(OP_UNKNOWN, '0, 1'b0);

		settle();
		repeat (80) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[auto_increment_key_generator] OK");
		end else begin
			$display("[auto_increment_key_generator] ERROR");
		end
		$finish;
	end

endmodule

// ===== auto_increment_key_generator.f =====
rtl/aikg_pkg.sv
rtl/aikg_ctrl.sv
rtl/aikg_dp.sv
rtl/auto_increment_key_generator.sv
verif/aikg_key_checker.sv
verif/auto_increment_key_generator_tb.sv
